[rtl/wsd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
// Used by wsd_parser, wsd_emitter and websocket_frame_deframer_top.
`default_nettype none
package wsd_pkg;

    // Kind of a pending result request from the parser to the emitter
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_PONG   = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    // Result routes
    localparam logic [1:0] ROUTE_APP   = 2'd0;
    localparam logic [1:0] ROUTE_TX    = 2'd1;
    localparam logic [1:0] ROUTE_DROP  = 2'd2;
    localparam logic [1:0] ROUTE_CLOSE = 2'd3;

    // Frame opcodes and header values
    localparam logic [3:0] OP_PING     = 4'd9;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [7:0] PONG_HDR    = 8'h8A;
    localparam logic [31:0] PING_MAX   = 32'd125;
    localparam logic [31:0] MAX_RESET  = 32'd65535;
    localparam logic [2:0] CLOSE_LAST  = 3'd6;
    localparam logic [2:0] CLOSE_END   = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] route;
        logic [7:0] data;
        logic       byte_valid;
        logic [3:0] opcode;
        logic       msg_end;
    } desc_t;

    typedef struct packed {
        logic [1:0] route;
        logic [7:0] data;
        logic       byte_valid;
        logic [3:0] opcode;
        logic       msg_end;
        logic       last;
    } result_t;

    // Close frame 88 05 "Error"
    function automatic logic [7:0] close_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h88;
            3'd1:    b = 8'h05;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'h72;
            3'd4:    b = 8'h72;
            3'd5:    b = 8'h6F;
            3'd6:    b = 8'h72;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[rtl/websocket_frame_deframer_top.sv]
// WebSocket frame deframer, top level.
// Depends on wsd_pkg, wsd_parser and wsd_emitter.
//
// s_* takes raw client bytes, one per request. m_* returns results: unmasked
// payload for the application, bytes to transmit (pong, close frame), a drop
// event or a websocket-closed event. cfg_* writes max_payload at any time the
// block is idle; it is always ready.
// The first result of an accepted byte is loaded into the result register in
// wsd_emitter. Throughput: one byte per cycle while results are taken. A byte
// with one or no result never stalls the input while m_tready is high. A ping
// header that completes holds the input until both pong header bytes go out;
// a close sequence holds it until its eight results are taken. Rate is set by
// the single result register in wsd_emitter, expanding one request per byte.
// When m_tready is low the pending result holds and s_tready stays low until
// that result is taken; with the result register empty a byte is always taken.
// Reset (aresetn low, synchronous) returns to the first header byte, opens
// the connection and sets max_payload to 65535. After a drop or a close all
// further bytes are accepted and discarded until reset.
`default_nettype none
module websocket_frame_deframer_top import wsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data
    output logic [7:0]       m_tuser,   // [1:0] route, [2] byte_valid, [6:3] frame_opcode, [7] last
    output logic             m_tlast,   // message_end
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic    accept;
    logic    desc_load;
    desc_t   desc;
    result_t result;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .desc_load (desc_load),
        .desc      (desc)
    );

    wsd_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (desc_load),
        .desc      (desc),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tdata = result.data;
    assign m_tuser = {result.last, result.opcode, result.byte_valid, result.route};
    assign m_tlast = result.msg_end;

endmodule
`default_nettype wire

[rtl/wsd_parser.sv]
// Header parser, length/mask check and payload unmasking, one byte per cycle while bytes are accepted.
// Depends on wsd_pkg; hands result requests to wsd_emitter.
`default_nettype none
module wsd_parser import wsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_value,
    output logic             desc_load,
    output desc_t            desc
);

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [31:0] max_payload_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    // low 32 bits of the length plus a sticky flag for anything above them
    logic [31:0] len_reg, len_next;
    logic        len_hi_reg, len_hi_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic        closed_reg, closed_next;
    logic        mseen_reg, mseen_next;

    logic        check;
    logic        hdr_done;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic        pay_end;

    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        len_hi_next = len_hi_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        closed_next = closed_reg;
        mseen_next  = mseen_reg;
        desc_load   = 1'b0;
        desc        = '0;
        check       = 1'b0;
        hdr_done    = 1'b0;
        key_byte    = 8'h00;
        plain       = 8'h00;
        pay_end     = 1'b0;

        if (accept && !closed_reg) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    fin_next   = rx_byte[7];
                    op_next    = rx_byte[3:0];
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    mseen_next  = rx_byte[7];
                    hcount_next = '0;
                    len_next    = '0;
                    len_hi_next = 1'b0;
                    if (rx_byte[6:0] == LEN_EXT16) begin
                        phase_next = PH_EXT16;
                    end else if (rx_byte[6:0] == LEN_EXT64) begin
                        phase_next = PH_EXT64;
                    end else begin
                        len_next = {25'd0, rx_byte[6:0]};
                        check    = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    len_next    = {len_reg[23:0], rx_byte};
                    len_hi_next = len_hi_reg | (len_reg[31:24] != 8'h00);
                    hcount_next = hcount_reg + 4'd1;
                    if (hcount_next >= ((phase_reg == PH_EXT16) ? 4'd2 : 4'd8)) begin
                        check = 1'b1;
                    end
                end
                PH_MASK: begin
                    key_next    = {key_reg[23:0], rx_byte};
                    hcount_next = hcount_reg + 4'd1;
                    if (hcount_next >= 4'd4) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    unique case (pos_reg)
                        2'd0: key_byte = key_reg[31:24];
                        2'd1: key_byte = key_reg[23:16];
                        2'd2: key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    plain    = rx_byte ^ key_byte;
                    pos_next = pos_reg + 2'd1;
                    len_next = (len_reg != 32'd0) ? len_reg - 32'd1 : 32'd0;
                    pay_end  = (len_next == 32'd0);
                    desc_load       = 1'b1;
                    desc.kind       = KIND_SINGLE;
                    desc.data       = plain;
                    desc.byte_valid = 1'b1;
                    desc.msg_end    = pay_end;
                    if (op_reg == OP_PING) begin
                        desc.route = ROUTE_TX;
                    end else begin
                        desc.route  = ROUTE_APP;
                        desc.opcode = op_reg;
                    end
                    if (pay_end) begin
                        phase_next = PH_HDR1;
                    end
                end
                default: phase_next = PH_HDR1;
            endcase

            // full length known: mask and size check
            if (check) begin
                if (!mseen_next || len_hi_next || (len_next > max_payload_reg)) begin
                    desc_load   = 1'b1;
                    desc.kind   = KIND_SINGLE;
                    desc.route  = ROUTE_DROP;
                    closed_next = 1'b1;
                end else begin
                    phase_next  = PH_MASK;
                    hcount_next = '0;
                    key_next    = '0;
                end
            end

            // mask key complete
            if (hdr_done) begin
                pos_next = '0;
                if (!fin_reg || (op_reg == OP_PING && (len_hi_reg || len_reg > PING_MAX))) begin
                    desc_load   = 1'b1;
                    desc.kind   = KIND_CLOSE;
                    closed_next = 1'b1;
                end else begin
                    if (op_reg == OP_PING) begin
                        desc_load    = 1'b1;
                        desc.kind    = KIND_PONG;
                        desc.route   = ROUTE_TX;
                        desc.data    = len_reg[7:0];
                        desc.msg_end = (len_reg == 32'd0);
                    end else if (len_reg == 32'd0) begin
                        desc_load    = 1'b1;
                        desc.kind    = KIND_SINGLE;
                        desc.route   = ROUTE_APP;
                        desc.opcode  = op_reg;
                        desc.msg_end = 1'b1;
                    end
                    phase_next = (len_reg != 32'd0) ? PH_PAYLOAD : PH_HDR1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_RESET;
            phase_reg       <= PH_HDR1;
            hcount_reg      <= '0;
            fin_reg         <= 1'b0;
            op_reg          <= '0;
            len_reg         <= '0;
            len_hi_reg      <= 1'b0;
            key_reg         <= '0;
            pos_reg         <= '0;
            closed_reg      <= 1'b0;
            mseen_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_payload_reg <= cfg_value;
            end
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            len_reg    <= len_next;
            len_hi_reg <= len_hi_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            closed_reg <= closed_next;
            mseen_reg  <= mseen_next;
        end
    end

endmodule
`default_nettype wire

[rtl/wsd_emitter.sv]
// Result register: holds one request and expands it into one, two or eight results.
// Depends on wsd_pkg; fed by wsd_parser.
`default_nettype none
module wsd_emitter import wsd_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  load,
    input  wire desc_t desc,
    output logic       ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    result
);

    desc_t      desc_reg;
    logic       valid_reg;
    logic [2:0] idx_reg;
    logic       final_res;

    always_comb begin
        result    = '0;
        final_res = 1'b1;
        unique case (desc_reg.kind)
            KIND_PONG: begin
                result.route      = ROUTE_TX;
                result.byte_valid = 1'b1;
                if (idx_reg == 3'd0) begin
                    result.data = PONG_HDR;
                    final_res   = 1'b0;
                end else begin
                    result.data    = desc_reg.data;
                    result.msg_end = desc_reg.msg_end;
                end
            end
            KIND_CLOSE: begin
                if (idx_reg == CLOSE_END) begin
                    result.route = ROUTE_CLOSE;
                end else begin
                    result.route      = ROUTE_TX;
                    result.data       = close_byte(idx_reg);
                    result.byte_valid = 1'b1;
                    result.msg_end    = (idx_reg == CLOSE_LAST);
                    final_res         = 1'b0;
                end
            end
            default: begin
                result.route      = desc_reg.route;
                result.data       = desc_reg.data;
                result.byte_valid = desc_reg.byte_valid;
                result.opcode     = desc_reg.opcode;
                result.msg_end    = desc_reg.msg_end;
            end
        endcase
        result.last = final_res;
    end

    assign out_valid = valid_reg;
    assign ready     = !valid_reg || (out_ready && final_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && out_ready) begin
            if (final_res) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc;
        end
    end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for websocket_frame_deframer_top: random WebSocket client frames
// in, every result compared against an in-bench deframer prediction.
// Depends on wsd_pkg and the deframer RTL.
module testbench;
    import wsd_pkg::*;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BIN    = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [55:0] CLOSE_FRAME = {8'h88, 8'h05, "Error"};
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES  = 150;

    typedef enum logic [2:0] {P_HDR1, P_HDR2, P_EXT16, P_EXT64, P_MASK, P_BODY} parse_e;
    typedef enum int {LEN7, LEN16, LEN64} len_form_e;
    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_CHOPPY} sink_mode_e;
    typedef enum int {END_UNMASKED, END_OVERSIZE, END_FRAGMENT, END_LONG_PING} ending_e;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = 32'd0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;
    wire  [7:0]  m_tuser;
    wire         m_tlast;
    wire         cfg_ready;

    websocket_frame_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // client bytes waiting to be sent, and results the deframer owes us
    logic [7:0] tx_bytes[$];
    result_t    due_results[$];
    int         bytes_pushed  = 0;
    int         bytes_offered = 0;
    int         bytes_taken   = 0;
    int         fail_count    = 0;
    int         cycle_count   = 0;
    bit         hold_req      = 1'b0;

    // predicted deframer state
    logic [31:0] max_len;
    parse_e      pstate;
    logic [3:0]  hdr_cnt;
    logic        fin_q;
    logic [3:0]  op_q;
    logic [63:0] rem_len;
    logic [31:0] mask_key;
    logic [1:0]  key_pos;
    logic        shut;
    logic        has_mask;
    result_t     step_out[8];
    int          step_n;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 100)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        fail_count++;
    endtask

    task automatic emit(input logic [1:0] route, input logic [7:0] d, input logic v,
                        input logic [3:0] op, input logic e);
        result_t r;
        r.route      = route;
        r.data       = d;
        r.byte_valid = v;
        r.opcode     = op;
        r.msg_end    = e;
        r.last       = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endtask

    task automatic check_length();
        if (!has_mask || rem_len > {32'd0, max_len}) begin
            emit(ROUTE_DROP, 8'd0, 1'b0, 4'd0, 1'b0);
            shut = 1'b1;
        end else begin
            pstate   = P_MASK;
            hdr_cnt  = 4'd0;
            mask_key = 32'd0;
        end
    endtask

    task automatic finish_header();
        key_pos = 2'd0;
        if (!fin_q || (op_q == OP_PING && rem_len > {32'd0, PING_MAX})) begin
            for (int i = 0; i < 7; i++)
                emit(ROUTE_TX, CLOSE_FRAME[8 * (6 - i) +: 8], 1'b1, 4'd0, i == 6);
            emit(ROUTE_CLOSE, 8'd0, 1'b0, 4'd0, 1'b0);
            shut = 1'b1;
            return;
        end
        if (op_q == OP_PING) begin
            emit(ROUTE_TX, PONG_HDR, 1'b1, 4'd0, 1'b0);
            emit(ROUTE_TX, rem_len[7:0], 1'b1, 4'd0, rem_len == 64'd0);
        end else if (rem_len == 64'd0) begin
            emit(ROUTE_APP, 8'd0, 1'b0, op_q, 1'b1);
        end
        pstate = (rem_len != 64'd0) ? P_BODY : P_HDR1;
    endtask

    // one client byte in, zero or more results queued
    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        logic [7:0] u;
        logic done;
        step_n = 0;
        if (!shut) begin
            case (pstate)
                P_HDR1: begin
                    fin_q  = b[7];
                    op_q   = b[3:0];
                    pstate = P_HDR2;
                end
                P_HDR2: begin
                    has_mask = b[7];
                    hdr_cnt  = 4'd0;
                    rem_len  = 64'd0;
                    if (b[6:0] == LEN_EXT16)
                        pstate = P_EXT16;
                    else if (b[6:0] == LEN_EXT64)
                        pstate = P_EXT64;
                    else begin
                        rem_len = {57'd0, b[6:0]};
                        check_length();
                    end
                end
                P_EXT16, P_EXT64: begin
                    rem_len = {rem_len[55:0], b};
                    hdr_cnt++;
                    if (hdr_cnt >= ((pstate == P_EXT16) ? 4'd2 : 4'd8))
                        check_length();
                end
                P_MASK: begin
                    mask_key = {mask_key[23:0], b};
                    hdr_cnt++;
                    if (hdr_cnt >= 4'd4)
                        finish_header();
                end
                P_BODY: begin
                    u = b ^ mask_key[8 * (3 - int'(key_pos)) +: 8];
                    key_pos++;
                    if (rem_len != 64'd0)
                        rem_len--;
                    done = (rem_len == 64'd0);
                    if (op_q == OP_PING)
                        emit(ROUTE_TX, u, 1'b1, 4'd0, done);
                    else
                        emit(ROUTE_APP, u, 1'b1, op_q, done);
                    if (done)
                        pstate = P_HDR1;
                end
                default: pstate = P_HDR1;
            endcase
        end
        for (int i = 0; i < step_n; i++) begin
            r = step_out[i];
            r.last = (i == step_n - 1);
            due_results.push_back(r);
        end
    endtask

    // predictor and result checker
    always @(posedge aclk) begin : scoreboard
        result_t want;
        if (!aresetn) begin
            max_len  = MAX_RESET;
            pstate   = P_HDR1;
            hdr_cnt  = 4'd0;
            fin_q    = 1'b0;
            op_q     = 4'd0;
            rem_len  = 64'd0;
            mask_key = 32'd0;
            key_pos  = 2'd0;
            shut     = 1'b0;
            has_mask = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                max_len = cfg_data;
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                bytes_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing pending",
                                    {m_tuser, m_tdata, m_tlast}, 64'd0);
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser[1:0] !== want.route)
                        report_mismatch("route", m_tuser[1:0], want.route);
                    if (m_tdata !== want.data)
                        report_mismatch("data", m_tdata, want.data);
                    if (m_tuser[2] !== want.byte_valid)
                        report_mismatch("byte_valid", m_tuser[2], want.byte_valid);
                    if (m_tuser[6:3] !== want.opcode)
                        report_mismatch("frame_opcode", m_tuser[6:3], want.opcode);
                    if (m_tlast !== want.msg_end)
                        report_mismatch("message_end", m_tlast, want.msg_end);
                    if (m_tuser[7] !== want.last)
                        report_mismatch("last", m_tuser[7], want.last);
                end
            end
        end
    end

    // sender: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin : byte_driver
        bit go;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
        end else if (!(s_tvalid && bytes_taken != bytes_offered)) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (tx_bytes.size() > 0) begin
                go = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    burst_left = 60;
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (go) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tx_bytes.pop_front();
                bytes_offered++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: switches between stall patterns, plus one long hold-off
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         mode_left = 0;
    int         tick      = 0;
    sink_mode_e sink_mode = SINK_OPEN;

    always @(negedge aclk) begin : result_sink
        bit rdy;
        tick++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = sink_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (sink_mode)
                SINK_OPEN:   rdy = 1'b1;
                SINK_RANDOM: rdy = ($urandom_range(0, 3) != 0);
                default:     rdy = ((tick % 8) < 3);
            endcase
        end
        m_tready <= rdy;
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[websocket_frame_deframer_top] ERROR");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // header, mask key and body bytes of one client frame; body bytes are random
    task automatic push_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input len_form_e form, input logic [63:0] len, input int body);
        logic [31:0] key;
        logic [2:0]  rsv;
        key = $urandom;
        rsv = $urandom_range(0, 7);
        push_byte({fin, rsv, op});
        case (form)
            LEN7: push_byte({masked, len[6:0]});
            LEN16: begin
                push_byte({masked, LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8 * i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            push_byte(key[8 * i +: 8]);
        for (int i = 0; i < body; i++)
            push_byte($urandom_range(0, 255));
    endtask

    // a frame that keeps the connection open under the given length limit
    task automatic push_good_frame(input logic [31:0] cap);
        logic [3:0]  op;
        logic [63:0] len;
        len_form_e   form;
        int          pick;
        int          top;
        pick = $urandom_range(0, 9);
        if (pick < 3)       op = OP_TEXT;
        else if (pick < 5)  op = OP_BIN;
        else if (pick < 7)  op = OP_PING;
        else if (pick == 7) op = OP_CLOSE;
        else if (pick == 8) op = OP_CONT;
        else                op = $urandom_range(0, 15);
        top = (cap > 32'd200) ? 200 : int'(cap);
        if (op == OP_PING && top > 125)
            top = 125;
        pick = $urandom_range(0, 15);
        if (pick == 0)       len = top;
        else if (pick < 10)  len = $urandom_range(0, (top < 12) ? top : 12);
        else if (pick < 14)  len = $urandom_range(0, (top < 60) ? top : 60);
        else                 len = $urandom_range(0, top);
        if (len > 64'd125)
            form = len_form_e'($urandom_range(1, 2));
        else
            form = len_form_e'($urandom_range(0, 2));
        push_frame(1'b1, op, 1'b1, form, len, int'(len));
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (tx_bytes.size() != 0 || bytes_taken != bytes_offered || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max(input logic [31:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        ending_e     ending;
        logic [31:0] lim;
        logic [63:0] len;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default limit: empty frames, ping echo, client close via 64-bit length
        push_frame(1'b1, OP_TEXT, 1'b1, LEN7, 64'd0, 0);
        push_frame(1'b1, OP_PING, 1'b1, LEN7, 64'd0, 0);
        push_frame(1'b1, OP_PING, 1'b1, LEN16, 64'd2, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_frame(1'b1, OP_CLOSE, 1'b1, LEN64, 64'd2, 0);
        push_byte(8'hFF);
        push_byte(8'h00);
        wait_idle();

        // zero limit: only empty frames pass
        write_max(32'd0);
        while (bytes_pushed < 110)
            push_good_frame(32'd0);
        wait_idle();

        // widest limit, with the receiver held off for a while
        write_max(32'hFFFF_FFFF);
        hold_req = 1'b1;
        while (bytes_pushed < 280)
            push_good_frame(32'hFFFF_FFFF);
        wait_idle();

        // random limit; some frames sit exactly on it
        lim = $urandom_range(1, 200);
        write_max(lim);
        while (bytes_pushed < 440)
            push_good_frame(lim);
        wait_idle();

        // one connection-ending frame, then bytes that must be ignored
        ending = ending_e'($urandom_range(0, 3));
        case (ending)
            END_UNMASKED: begin
                write_max($urandom_range(0, 1) ? MAX_RESET : 32'hFFFF_FFFF);
                len = $urandom_range(0, 20);
                push_frame(1'b1, $urandom_range(0, 15), 1'b0,
                           len_form_e'($urandom_range(0, 2)), len, 3);
            end
            END_OVERSIZE: begin
                lim = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 300);
                write_max(lim);
                if ($urandom_range(0, 1)) begin
                    len = {$urandom, $urandom};
                    len[63] = 1'b1;
                    push_frame(1'b1, OP_BIN, 1'b1, LEN64, len, 3);
                end else begin
                    len = {32'd0, lim} + 64'd1;
                    push_frame(1'b1, OP_TEXT, 1'b1, (len > 64'd125) ? LEN16 : LEN7, len, 3);
                end
            end
            END_FRAGMENT: begin
                write_max(MAX_RESET);
                len = $urandom_range(0, 10);
                push_frame(1'b0, $urandom_range(0, 15), 1'b1,
                           len_form_e'($urandom_range(0, 2)), len, int'(len) + 2);
            end
            default: begin
                write_max(32'hFFFF_FFFF);
                len = $urandom_range(126, 300);
                push_frame(1'b1, OP_PING, 1'b1, len_form_e'($urandom_range(1, 2)), len, 4);
            end
        endcase
        for (int i = 0; i < 8; i++)
            push_byte($urandom_range(0, 255));
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("[websocket_frame_deframer_top] OK");
        else
            $display("[websocket_frame_deframer_top] ERROR");
        $finish;
    end

endmodule
